[hdl/hrsp_pkg.sv]
// ----------------------------------------------------------------------------
// HTTP response stream parser package
// Shared types, character codes and limits for the response parser.
// ----------------------------------------------------------------------------
package hrsp_pkg;

    localparam int BODY_LIMIT = 1024;
    localparam int BODY_INDEX_W = ($clog2(BODY_LIMIT + 1) > 16) ? $clog2(BODY_LIMIT + 1) : 16;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [3:0]  KEY_LEN    = 4'd14;
    localparam logic [3:0]  KEY_POS_MAX = 4'd15;
    localparam logic [10:0] LINE_MAX   = 11'd2047;
    localparam logic [13:0] STATUS_MAX = 14'd999;
    localparam logic [19:0] VALUE_MAX  = 20'd65535;

    typedef logic [BODY_INDEX_W-1:0] body_index_t;

    typedef enum logic [1:0] {
        PH_STATUS,
        PH_HEADER,
        PH_BODY
    } phase_t;

    typedef enum logic [1:0] {
        ST_WAIT_SPACE,
        ST_CODE,
        ST_DONE
    } status_token_t;

    typedef enum logic [1:0] {
        IV_KEY,
        IV_SPACES,
        IV_DIGITS,
        IV_SKIP
    } in_value_t;

    typedef enum logic [1:0] {
        KIND_BODY,
        KIND_HDR_DONE,
        KIND_STOP
    } kind_t;

    typedef enum logic {
        ACT_BYTE,
        ACT_STOP
    } action_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  body_byte;
        logic        last;
        logic [9:0]  status_code;
        logic [15:0] content_length;
        logic        length_known;
        logic [10:0] body_count;
    } result_t;

    function automatic logic [7:0] key_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h43;
            4'd1:    c = 8'h6F;
            4'd2:    c = 8'h6E;
            4'd3:    c = 8'h74;
            4'd4:    c = 8'h65;
            4'd5:    c = 8'h6E;
            4'd6:    c = 8'h74;
            4'd7:    c = 8'h2D;
            4'd8:    c = 8'h4C;
            4'd9:    c = 8'h65;
            4'd10:   c = 8'h6E;
            4'd11:   c = 8'h67;
            4'd12:   c = 8'h74;
            4'd13:   c = 8'h68;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

[hdl/http_response_stream_parser_top.sv]
// ----------------------------------------------------------------------------
// HTTP response stream parser
// Parses a response byte stream into header-done, body-byte and stop results.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  in       input      in_valid / in_stall  action, rx_byte
//  out      output     out_valid/out_stall  kind, body_byte, last, status_code,
//                                           content_length, length_known,
//                                           body_count
//
// Each input transfer is parsed combinationally; a new one is taken every cycle unless in_stall is high.
// A result reaches the output register in the cycle after its input transfer when
// the output is free; under output stall it waits in a skid stage instead.
// Reset returns the parser to the status line and empties both result stages.
// in_stall rises only while the skid stage is full, that is once a second
// result arrives while the output is stalled.
// ----------------------------------------------------------------------------
module http_response_stream_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  body_byte,
    output logic        last,
    output logic [9:0]  status_code,
    output logic [15:0] content_length,
    output logic        length_known,
    output logic [10:0] body_count
);
    import hrsp_pkg::*;

    logic    fire;
    logic    res_valid;
    logic    full;
    result_t res;
    result_t out_data;

    assign in_stall = full;
    assign fire     = in_valid && !full;

    hrsp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .action    (action),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    hrsp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign kind           = out_data.kind;
    assign body_byte      = out_data.body_byte;
    assign last           = out_data.last;
    assign status_code    = out_data.status_code;
    assign content_length = out_data.content_length;
    assign length_known   = out_data.length_known;
    assign body_count     = out_data.body_count;

endmodule

[hdl/hrsp_core.sv]
// ----------------------------------------------------------------------------
// HTTP response parser core
// Parser state registers and the combinational next-state and result logic.
// ----------------------------------------------------------------------------
module hrsp_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic             action,
    input  logic [7:0]       rx_byte,
    output logic             res_valid,
    output hrsp_pkg::result_t res
);
    import hrsp_pkg::*;

    phase_t        phase_reg, phase_next;
    status_token_t status_token_reg, status_token_next;
    logic [9:0]    status_value_reg, status_value_next;
    logic [10:0]   line_bytes_reg, line_bytes_next;
    logic [3:0]    key_position_reg, key_position_next;
    logic          key_matches_reg, key_matches_next;
    in_value_t     in_value_reg, in_value_next;
    logic [15:0]   value_acc_reg, value_acc_next;
    logic [15:0]   declared_length_reg, declared_length_next;
    logic          has_length_reg, has_length_next;
    body_index_t   body_index_reg, body_index_next;

    logic          is_digit;
    logic [3:0]    digit;
    logic [13:0]   status_prod;
    logic [19:0]   value_prod;
    logic [10:0]   line_inc;
    body_index_t   declared_ext;
    body_index_t   length_step;

    assign is_digit     = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign digit        = rx_byte[3:0];
    assign status_prod  = 14'(status_value_reg) * 14'd10 + {10'd0, digit};
    assign value_prod   = 20'(value_acc_reg) * 20'd10 + {16'd0, digit};
    assign line_inc     = (line_bytes_reg < LINE_MAX) ? line_bytes_reg + 11'd1 : line_bytes_reg;
    assign declared_ext = BODY_INDEX_W'(declared_length_reg);
    assign length_step  = (body_index_reg < declared_ext) ? body_index_reg + body_index_t'(1)
                                                          : body_index_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_STATUS;
            status_token_reg    <= ST_WAIT_SPACE;
            status_value_reg    <= '0;
            line_bytes_reg      <= '0;
            key_position_reg    <= '0;
            key_matches_reg     <= 1'b1;
            in_value_reg        <= IV_KEY;
            value_acc_reg       <= '0;
            declared_length_reg <= '0;
            has_length_reg      <= 1'b0;
            body_index_reg      <= '0;
        end
        else
        begin
            phase_reg           <= phase_next;
            status_token_reg    <= status_token_next;
            status_value_reg    <= status_value_next;
            line_bytes_reg      <= line_bytes_next;
            key_position_reg    <= key_position_next;
            key_matches_reg     <= key_matches_next;
            in_value_reg        <= in_value_next;
            value_acc_reg       <= value_acc_next;
            declared_length_reg <= declared_length_next;
            has_length_reg      <= has_length_next;
            body_index_reg      <= body_index_next;
        end
    end

    always_comb
    begin
        phase_next           = phase_reg;
        status_token_next    = status_token_reg;
        status_value_next    = status_value_reg;
        line_bytes_next      = line_bytes_reg;
        key_position_next    = key_position_reg;
        key_matches_next     = key_matches_reg;
        in_value_next        = in_value_reg;
        value_acc_next       = value_acc_reg;
        declared_length_next = declared_length_reg;
        has_length_next      = has_length_reg;
        body_index_next      = body_index_reg;
        res_valid            = 1'b0;
        res                  = '0;

        if (fire)
        begin
            if (action == ACT_STOP)
            begin
                if (!has_length_reg)
                begin
                    res_valid       = 1'b1;
                    res.kind        = KIND_STOP;
                    res.body_count  = body_index_reg[10:0];
                    body_index_next = '0;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_STATUS:
                    begin
                        if (rx_byte == CH_LF)
                        begin
                            phase_next        = PH_HEADER;
                            line_bytes_next   = '0;
                            key_position_next = '0;
                            key_matches_next  = 1'b1;
                            in_value_next     = IV_KEY;
                            value_acc_next    = '0;
                        end
                        else if (status_token_reg == ST_WAIT_SPACE)
                        begin
                            if (rx_byte == CH_SPACE)
                            begin
                                status_token_next = ST_CODE;
                            end
                        end
                        else if (status_token_reg == ST_CODE)
                        begin
                            if (is_digit)
                            begin
                                status_value_next = (status_prod > STATUS_MAX) ? 10'd999
                                                                               : status_prod[9:0];
                            end
                            else
                            begin
                                status_token_next = ST_DONE;
                            end
                        end
                    end
                    PH_HEADER:
                    begin
                        line_bytes_next = line_inc;
                        if (rx_byte == CH_LF)
                        begin
                            if (line_inc == 11'd2)
                            begin
                                phase_next         = PH_BODY;
                                body_index_next    = '0;
                                res_valid          = 1'b1;
                                res.kind           = KIND_HDR_DONE;
                                res.status_code    = status_value_reg;
                                res.content_length = declared_length_reg;
                                res.length_known   = has_length_reg;
                            end
                            else if ((in_value_reg != IV_KEY) && key_matches_reg)
                            begin
                                declared_length_next = value_acc_reg;
                                has_length_next      = 1'b1;
                            end
                            line_bytes_next   = '0;
                            key_position_next = '0;
                            key_matches_next  = 1'b1;
                            in_value_next     = IV_KEY;
                            value_acc_next    = '0;
                        end
                        else
                        begin
                            case (in_value_reg)
                                IV_KEY:
                                begin
                                    if (rx_byte == CH_COLON)
                                    begin
                                        if (key_matches_reg && (key_position_reg == KEY_LEN))
                                        begin
                                            in_value_next = IV_SPACES;
                                        end
                                        else
                                        begin
                                            key_matches_next = 1'b0;
                                            in_value_next    = IV_SKIP;
                                        end
                                    end
                                    else
                                    begin
                                        if ((key_position_reg >= KEY_LEN)
                                            || (rx_byte != key_char(key_position_reg)))
                                        begin
                                            key_matches_next = 1'b0;
                                        end
                                        if (key_position_reg < KEY_POS_MAX)
                                        begin
                                            key_position_next = key_position_reg + 4'd1;
                                        end
                                    end
                                end
                                IV_SPACES:
                                begin
                                    if (is_digit)
                                    begin
                                        value_acc_next = {12'd0, digit};
                                        in_value_next  = IV_DIGITS;
                                    end
                                    else if (rx_byte != CH_SPACE)
                                    begin
                                        in_value_next = IV_SKIP;
                                    end
                                end
                                IV_DIGITS:
                                begin
                                    if (is_digit)
                                    begin
                                        value_acc_next = (value_prod > VALUE_MAX) ? 16'hFFFF
                                                                                  : value_prod[15:0];
                                    end
                                    else
                                    begin
                                        in_value_next = IV_SKIP;
                                    end
                                end
                                default:
                                begin
                                    in_value_next = IV_SKIP;
                                end
                            endcase
                        end
                    end
                    default:
                    begin
                        res_valid     = 1'b1;
                        res.kind      = KIND_BODY;
                        res.body_byte = rx_byte;
                        if (has_length_reg)
                        begin
                            body_index_next = length_step;
                            if (length_step == declared_ext)
                            begin
                                res.last        = 1'b1;
                                body_index_next = '0;
                                has_length_next = 1'b0;
                            end
                        end
                        else if (body_index_reg < BODY_INDEX_W'(BODY_LIMIT))
                        begin
                            body_index_next = body_index_reg + body_index_t'(1);
                        end
                    end
                endcase
            end
        end
    end

    a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
        has_length_reg |-> (body_index_reg <= declared_ext))
        else $error("body index passed the declared length");

    a_limit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !has_length_reg |-> (body_index_reg <= BODY_INDEX_W'(BODY_LIMIT)))
        else $error("unlengthed body count passed its limit");

endmodule

[hdl/hrsp_out_buf.sv]
// ----------------------------------------------------------------------------
// HTTP response parser output buffer
// Output register with skid stage: input continues under stall until it fills.
// ----------------------------------------------------------------------------
module hrsp_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_valid,
    input  hrsp_pkg::result_t res,
    output logic             full,
    output logic             out_valid,
    input  logic             out_stall,
    output hrsp_pkg::result_t out_data
);
    import hrsp_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = res_valid;
                skid_data_next  = res;
            end
            else
            begin
                out_valid_next = res_valid;
                out_data_next  = res;
            end
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a result while the output register is empty");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !skid_valid_reg)
        else $error("result arrived while the skid stage was full");

    a_skid_moves_up: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_stall) |=> (out_valid_reg && (out_data_reg == $past(skid_data_reg))))
        else $error("skid result was not moved into the output register");

endmodule
